[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define U8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define U8SD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/u8sd_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Word and result types and the decoding constants of the block.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  // One input word: a raw byte and its end-of-string mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_word_t;

  // Contents of the input register.
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  // One decoded result.
  typedef struct packed {
    logic [31:0] code_point;
    logic [2:0]  seq_length;
    logic        printable;
  } result_t;

  // Decoder to output register: a result and whether one is produced.
  typedef struct packed {
    logic    valid;
    result_t res;
  } dec_t;

  localparam logic [31:0] ERR_CODE   = 32'hFFFF_FFFF;
  localparam logic [2:0]  LEN_ERR    = 3'd0;
  localparam logic [2:0]  LEN_ONE    = 3'd1;
  localparam logic [3:0]  LEAD_MIN   = 4'd2;
  localparam logic [3:0]  LEAD_MAX   = 4'd6;
  localparam logic [1:0]  CONT_TAG   = 2'b10;

  // Largest value that each shorter form can carry.
  localparam logic [31:0] MAX_1B     = 32'h0000_007F;
  localparam logic [31:0] MAX_2B     = 32'h0000_07FF;
  localparam logic [31:0] MAX_3B     = 32'h0000_FFFF;
  localparam logic [31:0] MAX_4B     = 32'h001F_FFFF;
  localparam logic [31:0] MAX_5B     = 32'h03FF_FFFF;

  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
  localparam logic [31:0] CTRL_MAX   = 32'h0000_001F;
  localparam logic [31:0] CTRL2_LO   = 32'h0000_007F;
  localparam logic [31:0] CTRL2_HI   = 32'h0000_009F;

endpackage

[rtl/u8sd_if.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channel interfaces for input bytes and decoded results.
// ----------------------------------------------------------------------------

// Input byte channel.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// Decoded result channel.
interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [2:0]  seq_length;
  logic        printable;

  modport source (output valid, output code_point, output seq_length, output printable,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input printable,
                  output ready);
endinterface

[rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream of original UTF-8, sequences of one to six bytes.
//
//   Channel  Direction  Word contents
//   in_word  sink       data_byte[7:0], end_of_string
//   out_word source     code_point[31:0], seq_length[2:0], printable
//
// One byte word is accepted every cycle while the result side keeps up.
// A result word is presented after its final byte is accepted: the byte is
// held in the input register, then the decoded result is loaded into the
// output register, which presents it until it is taken.
// A stalled output register holds the decoder and then the input register.
// Reset (rst_n low, synchronous) empties both registers and idles the decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  u8sd_in_if.sink     in_word,
  u8sd_out_if.source  out_word
);

  u8sd_pkg::stage_t stage;
  u8sd_pkg::dec_t   dec;
  logic             out_free;
  logic             advance;

  logic             out_is_err;
  logic             out_is_one;
  logic             err_shape_ok;
  logic             one_range_ok;
  logic             stage_stall;

  // The decoder consumes a byte when one is held and the result side has room.
  assign advance = stage.valid && out_free;

  u8sd_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .advance (advance),
    .stage   (stage)
  );

  u8sd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .dec     (dec)
  );

  u8sd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .dec      (dec),
    .out_free (out_free),
    .out_word (out_word)
  );

  // Shape of the presented result word and the input register stall.
  assign out_is_err   = out_word.valid && (out_word.seq_length == u8sd_pkg::LEN_ERR);
  assign out_is_one   = out_word.valid && (out_word.seq_length == u8sd_pkg::LEN_ONE);
  assign err_shape_ok = (out_word.code_point == u8sd_pkg::ERR_CODE) && !out_word.printable;
  assign one_range_ok = out_word.code_point <= u8sd_pkg::MAX_1B;
  assign stage_stall  = stage.valid && !advance;

  // Checks.
  `U8SD_ASSERT(a_err_shape, out_is_err |-> err_shape_ok, "error result not all ones")
  `U8SD_ASSERT(a_one_byte, out_is_one |-> one_range_ok, "one-byte result out of range")
  `U8SD_ASSERT(a_no_drop, dec.valid |-> out_free, "result produced without room")
  `U8SD_ASSERT_NEXT(a_stage_hold, stage_stall, stage.valid && $stable(stage.word), "held byte lost")

endmodule

[rtl/u8sd_in_stage.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder input register
// Captures one word per cycle and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module u8sd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  u8sd_in_if.sink           in_word,
  input  logic              advance,
  output u8sd_pkg::stage_t  stage
);

  logic               valid_r;
  logic               valid_nxt;
  u8sd_pkg::in_word_t word_r;
  logic               take;

  // The register frees up in the same cycle that the decoder consumes it.
  assign in_word.ready = !valid_r || advance;
  assign take          = in_word.valid && in_word.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      word_r.data_byte     <= in_word.data_byte;
      word_r.end_of_string <= in_word.end_of_string;
    end
  end

  assign stage.valid = valid_r;
  assign stage.word  = word_r;

endmodule

[rtl/u8sd_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Sequence state and the per-byte decode, check and result logic.
// ----------------------------------------------------------------------------
module u8sd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  u8sd_pkg::stage_t  stage,
  input  logic              advance,
  output u8sd_pkg::dec_t    dec
);

  logic [2:0]  rem_r, rem_nxt;
  logic [2:0]  tot_r, tot_nxt;
  logic [30:0] acc_r, acc_nxt;

  logic [7:0]  b;
  logic        last;
  logic [3:0]  lead_ones;
  logic [7:0]  lead_mask;
  logic [30:0] acc_cont;
  logic [2:0]  rem_dec;
  logic [31:0] ch;
  logic        bad;
  logic        emit;
  logic        fail;
  logic [31:0] cp;
  logic [2:0]  len;

  assign b    = stage.word.data_byte;
  assign last = stage.word.end_of_string;

  // Count of leading ones of the byte.
  always_comb begin
    priority casez (b)
      8'b0???????: lead_ones = 4'd0;
      8'b10??????: lead_ones = 4'd1;
      8'b110?????: lead_ones = 4'd2;
      8'b1110????: lead_ones = 4'd3;
      8'b11110???: lead_ones = 4'd4;
      8'b111110??: lead_ones = 4'd5;
      8'b1111110?: lead_ones = 4'd6;
      8'b11111110: lead_ones = 4'd7;
      default:     lead_ones = 4'd8;
    endcase
  end

  // Value bits carried by a lead byte.
  always_comb begin
    unique case (lead_ones)
      4'd2:    lead_mask = 8'h1F;
      4'd3:    lead_mask = 8'h0F;
      4'd4:    lead_mask = 8'h07;
      4'd5:    lead_mask = 8'h03;
      4'd6:    lead_mask = 8'h01;
      default: lead_mask = 8'h00;
    endcase
  end

  // Continuation step and the final value checks.
  assign acc_cont = {acc_r[24:0], b[5:0]};
  assign rem_dec  = rem_r - 3'd1;
  assign ch       = {1'b0, acc_cont};
  assign bad = (ch <= u8sd_pkg::MAX_1B && tot_r > 3'd1)
            || (ch <= u8sd_pkg::MAX_2B && tot_r > 3'd2)
            || (ch <= u8sd_pkg::MAX_3B && tot_r > 3'd3)
            || (ch <= u8sd_pkg::MAX_4B && tot_r > 3'd4)
            || (ch <= u8sd_pkg::MAX_5B && tot_r > 3'd5)
            || (ch >= u8sd_pkg::SURR_LO && ch <= u8sd_pkg::SURR_HI);

  // Next state and result for the byte in the input register.
  always_comb begin
    rem_nxt = rem_r;
    tot_nxt = tot_r;
    acc_nxt = acc_r;
    emit    = 1'b0;
    fail    = 1'b0;
    cp      = u8sd_pkg::ERR_CODE;
    len     = u8sd_pkg::LEN_ERR;
    if (rem_r == 3'd0) begin
      if (!b[7]) begin
        emit = 1'b1;
        cp   = {24'd0, b};
        len  = u8sd_pkg::LEN_ONE;
      end else if (lead_ones < u8sd_pkg::LEAD_MIN || lead_ones > u8sd_pkg::LEAD_MAX
                   || last) begin
        fail = 1'b1;
      end else begin
        acc_nxt = {23'd0, b & lead_mask};
        tot_nxt = lead_ones[2:0];
        rem_nxt = lead_ones[2:0] - 3'd1;
      end
    end else if (b[7:6] != u8sd_pkg::CONT_TAG) begin
      fail = 1'b1;
    end else if (rem_dec == 3'd0) begin
      if (bad) begin
        fail = 1'b1;
      end else begin
        emit    = 1'b1;
        cp      = ch;
        len     = tot_r;
        rem_nxt = 3'd0;
        tot_nxt = 3'd0;
        acc_nxt = 31'd0;
      end
    end else if (last) begin
      fail = 1'b1;
    end else begin
      acc_nxt = acc_cont;
      rem_nxt = rem_dec;
    end

    // Any error returns the sequence state to idle.
    if (fail) begin
      emit    = 1'b1;
      rem_nxt = 3'd0;
      tot_nxt = 3'd0;
      acc_nxt = 31'd0;
    end
  end

  // Sequence state advances only when the word is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      tot_r <= 3'd0;
      acc_r <= 31'd0;
    end else if (advance) begin
      rem_r <= rem_nxt;
      tot_r <= tot_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign dec.valid          = advance && emit;
  assign dec.res.code_point = cp;
  assign dec.res.seq_length = len;
  assign dec.res.printable  = (len != u8sd_pkg::LEN_ERR) && (cp > u8sd_pkg::CTRL_MAX)
                            && !(cp >= u8sd_pkg::CTRL2_LO && cp <= u8sd_pkg::CTRL2_HI);

endmodule

[rtl/u8sd_out_stage.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module u8sd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  u8sd_pkg::dec_t   dec,
  output logic             out_free,
  u8sd_out_if.source       out_word
);

  logic              valid_r;
  u8sd_pkg::result_t res_r;

  // Room for a new result when empty or when the held one leaves now.
  assign out_free = !valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= dec.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_free && dec.valid) begin
      res_r <= dec.res;
    end
  end

  assign out_word.valid      = valid_r;
  assign out_word.code_point = res_r.code_point;
  assign out_word.seq_length = res_r.seq_length;
  assign out_word.printable  = res_r.printable;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends byte words through the input channel and checks every result word
// against a predictor that tracks the open sequence. A directed opening covers
// the edge bytes and each error case. Random strings follow: mostly well-formed
// sequences of one to six bytes, plus truncated and broken ones and noise.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sd_pkg::*;

  logic clk;
  logic rst_n;

  u8sd_in_if  in_if ();
  u8sd_out_if out_if ();

  utf8_stream_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if)
  );

  // Words waiting to be sent and results waiting to arrive.
  in_word_t pending_words[$];
  result_t  expected_results[$];

  // Predictor state: continuation bytes still due, sequence length, value so far.
  logic [2:0]  cont_left;
  logic [2:0]  seq_len;
  logic [30:0] acc_val;

  int mismatch_count;
  int words_sent;
  int words_accepted;
  int words_total;
  int results_checked;
  int error_results;
  int six_byte_results;

  // Sender burst and gap counters, receiver stall pattern.
  int          burst_left;
  int          gap_left;
  logic [15:0] stall_pattern;
  int          pattern_age;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h (result %0d)",
             what, got, want, results_checked);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic result_t make_result(input logic [31:0] cp, input logic [2:0] len);
    result_t r;
    r.code_point = cp;
    r.seq_length = len;
    r.printable  = (len != LEN_ERR) && (cp > CTRL_MAX) &&
                   !(cp >= CTRL2_LO && cp <= CTRL2_HI);
    return r;
  endfunction

  // A failed sequence drops all state and reports the error word.
  function automatic result_t abort_sequence();
    cont_left = 3'd0;
    seq_len   = 3'd0;
    acc_val   = '0;
    return make_result(ERR_CODE, LEN_ERR);
  endfunction

  // Advances the predictor by one byte; returns 1 when a result is due.
  function automatic bit utf8_decode_step(input logic [7:0] b, input logic eos,
                                          output result_t res);
    int          n;
    logic [31:0] ch;
    n   = 0;
    ch  = '0;
    res = '0;
    if (cont_left == 3'd0) begin
      if (!b[7]) begin
        res = make_result({24'd0, b}, LEN_ONE);
        return 1'b1;
      end
      while (n < 8 && b[7 - n]) n++;
      // A lone continuation, seven or eight leading ones, or a lead at the end.
      if (n < 2 || n > 6 || eos) begin
        res = abort_sequence();
        return 1'b1;
      end
      acc_val   = 31'(b & ((8'd1 << (7 - n)) - 8'd1));
      seq_len   = 3'(n);
      cont_left = 3'(n - 1);
      return 1'b0;
    end
    // The bad byte is consumed here, never reread as a lead.
    if (b[7:6] != CONT_TAG) begin
      res = abort_sequence();
      return 1'b1;
    end
    acc_val   = {acc_val[24:0], b[5:0]};
    cont_left = cont_left - 3'd1;
    if (cont_left == 3'd0) begin
      ch = {1'b0, acc_val};
      // Overlong forms and surrogates are rejected at completion.
      if ((ch <= MAX_1B && seq_len > 3'd1) || (ch <= MAX_2B && seq_len > 3'd2) ||
          (ch <= MAX_3B && seq_len > 3'd3) || (ch <= MAX_4B && seq_len > 3'd4) ||
          (ch <= MAX_5B && seq_len > 3'd5) || (ch >= SURR_LO && ch <= SURR_HI)) begin
        res = abort_sequence();
        return 1'b1;
      end
      res       = make_result(ch, seq_len);
      seq_len   = 3'd0;
      acc_val   = '0;
      return 1'b1;
    end
    if (eos) begin
      res = abort_sequence();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [7:0] b, input logic eos);
    in_word_t w;
    w.data_byte     = b;
    w.end_of_string = eos;
    pending_words.push_back(w);
  endtask

  // Encodes cp in n bytes; a value too small for n gives an overlong form.
  function automatic void encode_utf8(input logic [31:0] cp, input int n,
                                      output logic [7:0] enc [6]);
    for (int i = 0; i < 6; i++) enc[i] = 8'h00;
    if (n == 1) begin
      enc[0] = cp[7:0] & 8'h7F;
    end else begin
      enc[0] = (8'hFF << (8 - n)) | (8'(cp >> (6 * (n - 1))) & (8'hFF >> (n + 1)));
      for (int i = 1; i < n; i++)
        enc[i] = 8'h80 | (8'(cp >> (6 * (n - 1 - i))) & 8'h3F);
    end
  endfunction

  task automatic push_sequence(input logic [31:0] cp, input int n, input logic eos);
    logic [7:0] enc [6];
    encode_utf8(cp, n, enc);
    for (int i = 0; i < n; i++) push_word(enc[i], (i == n - 1) ? eos : 1'b0);
  endtask

  // A value for an n-byte form: usually in range, sometimes at an edge,
  // overlong, or near the surrogate block.
  function automatic logic [31:0] pick_code_point(input int n);
    logic [31:0] lo;
    logic [31:0] hi;
    int          r;
    r = $urandom_range(0, 99);
    case (n)
      1:       begin lo = 32'h0;         hi = MAX_1B;        end
      2:       begin lo = MAX_1B + 1;    hi = MAX_2B;        end
      3:       begin lo = MAX_2B + 1;    hi = MAX_3B;        end
      4:       begin lo = MAX_3B + 1;    hi = MAX_4B;        end
      5:       begin lo = MAX_4B + 1;    hi = MAX_5B;        end
      default: begin lo = MAX_5B + 1;    hi = 32'h7FFF_FFFF; end
    endcase
    if (n == 1 && r < 30) return $urandom_range(32, 0);
    if (n > 1 && r < 12) return $urandom_range(lo - 1, 0);
    if (n == 3 && r < 25) return $urandom_range(SURR_HI + 16, SURR_LO - 16);
    if (r < 28) return lo;
    if (r < 31) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // One random piece of a string.
  task automatic gen_random_piece();
    logic [7:0] enc [6];
    logic [7:0] junk;
    int         sel;
    int         n;
    int         cut;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      // Well-formed sequence, sometimes the last of its string.
      n = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 6);
      push_sequence(pick_code_point(n), n, $urandom_range(0, 7) == 0);
    end else if (sel < 90) begin
      // A sequence cut short: by the end of the string, by a foreign byte,
      // or simply abandoned so that the next piece arrives in its place.
      n   = $urandom_range(2, 6);
      cut = $urandom_range(1, n - 1);
      encode_utf8(pick_code_point(n), n, enc);
      case ($urandom_range(0, 2))
        0: begin
          for (int i = 0; i < cut; i++) push_word(enc[i], i == cut - 1);
        end
        1: begin
          for (int i = 0; i < cut; i++) push_word(enc[i], 1'b0);
          junk = 8'($urandom_range(0, 255));
          if (junk[7:6] == CONT_TAG) junk[6] = 1'b1;
          push_word(junk, 1'($urandom_range(0, 1)));
        end
        default: begin
          for (int i = 0; i < cut; i++) push_word(enc[i], 1'b0);
        end
      endcase
    end else begin
      // Noise byte.
      push_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends words in bursts with gaps and predicts each accepted word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_word_t next_word;
    result_t  res;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= $urandom_range(1, 32);
      gap_left    <= 0;
      cont_left    = 3'd0;
      seq_len      = 3'd0;
      acc_val      = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        words_accepted++;
        if (utf8_decode_step(in_if.data_byte, in_if.end_of_string, res))
          expected_results.push_back(res);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left    <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word              = pending_words.pop_front();
          in_if.data_byte       <= next_word.data_byte;
          in_if.end_of_string   <= next_word.end_of_string;
          in_if.valid           <= 1'b1;
          words_sent++;
          // At the end of a burst pick the next gap and burst length.
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a rotating pattern that is replaced when pattern_age wraps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      stall_pattern <= 16'hFFFF;
      pattern_age   <= 0;
    end else begin
      out_if.ready <= stall_pattern[0];
      if (pattern_age == 63) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'($urandom) | 16'h0001;
          2:       stall_pattern <= 16'($urandom | $urandom) | 16'h0001;
          default: stall_pattern <= 16'($urandom & $urandom & $urandom) | 16'h0001;
        endcase
      end else begin
        pattern_age   <= pattern_age + 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted result word with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_if.code_point, ERR_CODE);
      end else begin
        want = expected_results.pop_front();
        if (out_if.code_point !== want.code_point)
          report_mismatch("code_point", out_if.code_point, want.code_point);
        if (out_if.seq_length !== want.seq_length)
          report_mismatch("seq_length", 32'(out_if.seq_length), 32'(want.seq_length));
        if (out_if.printable !== want.printable)
          report_mismatch("printable", 32'(out_if.printable), 32'(want.printable));
        if (want.seq_length == LEN_ERR) error_results++;
        if (want.seq_length == 3'd6) six_byte_results++;
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = 8'h00;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;

    // Plain bytes at both ends of the range, control bytes among them.
    push_word(8'h00, 1'b0);
    push_word(8'h41, 1'b1);
    push_word(8'h7F, 1'b0);
    // Lone continuation and leads with seven or eight leading ones.
    push_word(8'h80, 1'b0);
    push_word(8'hFE, 1'b0);
    push_word(8'hFF, 1'b1);
    // Lead byte that ends the string.
    push_word(8'hC2, 1'b1);
    // Bad continuation; the plain byte after the lead is swallowed.
    push_word(8'hC3, 1'b0);
    push_word(8'h41, 1'b0);
    // String ends inside a three-byte sequence.
    push_word(8'hE2, 1'b0);
    push_word(8'h82, 1'b1);
    // Overlong NUL and the first surrogate.
    push_sequence(32'h0000_0000, 2, 1'b0);
    push_sequence(SURR_LO, 3, 1'b0);
    // Two-byte forms inside and just past the upper control range,
    // then the largest six-byte value.
    push_sequence(32'h0000_0080, 2, 1'b0);
    push_sequence(32'h0000_00A0, 2, 1'b0);
    push_sequence(32'h7FFF_FFFF, 6, 1'b1);

    while (pending_words.size() < 975) gen_random_piece();
    words_total = pending_words.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to go in and every result to come out.
    while (words_accepted < words_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Summary: %0d byte words sent, %0d results checked", words_sent,
             results_checked);
    $display("Summary: %0d error results, %0d six-byte sequences, %0d mismatches",
             error_results, six_byte_results, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
